/* hw/rtl/nld_pkg.sv */
`default_nettype none
// ============================================================================
// nld_pkg
// Shared types and constants of the nested list byte deframer.
// ============================================================================
package nld_pkg;

   localparam int MAX_DEPTH = 8;
   localparam int LVL_W     = 4;
   localparam int PTR_W     = $clog2(MAX_DEPTH);
   localparam int STK_W     = 32;

   localparam logic [7:0] KIND_LEAF   = 8'h42;
   localparam logic [7:0] KIND_BRANCH = 8'h4C;

   localparam logic [1:0] ROLE_KIND = 2'd0;
   localparam logic [1:0] ROLE_LEN  = 2'd1;
   localparam logic [1:0] ROLE_PAY  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_KIND  = 2'd1;
   localparam logic [1:0] STAT_AFTER = 2'd2;
   localparam logic [1:0] STAT_CUT   = 2'd3;

   typedef enum logic [2:0] {
      PH_KIND,
      PH_HEADER,
      PH_PAYLOAD,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_CLIMB,
      S_EMIT
   } fsm_type;

   typedef struct packed {
      logic [7:0]       value;
      logic [1:0]       role;
      logic [LVL_W-1:0] level;
      logic             leaf_end;
      logic             done;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [STK_W-1:0] wr_data;
   } ram_req_type;

endpackage
`default_nettype wire

/* hw/rtl/nld_ram.sv */
`default_nettype none
// ============================================================================
// nld_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module nld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/nld_rsp_reg.sv */
`default_nettype none
// ============================================================================
// nld_rsp_reg
// Output register between the deframer core and the result channel.
// ============================================================================
module nld_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire nld_pkg::rsp_type in_word,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output nld_pkg::rsp_type      out_word
);
   import nld_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

/* hw/rtl/nld_core.sv */
`default_nettype none
// ============================================================================
// nld_core
// Per-byte parse sequencer; child counts live in the stack RAM and are
// read, decremented and written back while a completed node unwinds.
// ============================================================================
module nld_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [7:0]                  in_byte,
   input  wire logic                        in_last,
   input  wire logic [nld_pkg::LVL_W-1:0]   list_depth,
   output logic                             res_valid,
   input  wire logic                        res_ready,
   output nld_pkg::rsp_type                 res_word,
   output nld_pkg::ram_req_type             ram_req,
   input  wire logic [nld_pkg::STK_W-1:0]   ram_rd_data
);
   import nld_pkg::*;

   localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_DEPTH);
   localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
   localparam logic [STK_W-1:0] STK_ONE = STK_W'(1);

   fsm_type          state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       hcnt_ff, hcnt_in;
   logic [STK_W-1:0] hval_ff, hval_in;
   logic [STK_W-1:0] pleft_ff, pleft_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [1:0]       err_ff, err_in;
   logic [LVL_W-1:0] clv_ff, clv_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [1:0]       role_ff, role_in;
   logic [LVL_W-1:0] rlvl_ff, rlvl_in;
   logic             leaf_ff, leaf_in;
   logic             done_ff, done_in;

   logic             accept;
   logic             climb;
   logic             climb_go;
   logic             climb_more;
   logic [LVL_W-1:0] eff_depth;
   logic             is_leaf;
   logic [STK_W-1:0] hval_shift;
   logic [LVL_W-1:0] lvl_dec;
   logic [LVL_W-1:0] parent;
   logic [LVL_W-1:0] parent_dec;
   logic [STK_W-1:0] cnt_dec;

   assign accept     = in_valid && in_ready;
   assign eff_depth  = (list_depth > MAX_LVL) ? MAX_LVL : list_depth;
   assign is_leaf    = level_ff >= eff_depth;
   assign hval_shift = {hval_ff[STK_W-9:0], byte_ff};
   assign lvl_dec    = level_ff - LVL_ONE;
   assign parent     = clv_ff - LVL_ONE;
   assign parent_dec = parent - LVL_ONE;
   assign cnt_dec    = ram_rd_data - STK_ONE;

   // datapath and stack access
   always_comb begin
      phase_in   = phase_ff;
      hcnt_in    = hcnt_ff;
      hval_in    = hval_ff;
      pleft_in   = pleft_ff;
      level_in   = level_ff;
      err_in     = err_ff;
      clv_in     = clv_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      role_in    = role_ff;
      rlvl_in    = rlvl_ff;
      leaf_in    = leaf_ff;
      done_in    = done_ff;
      climb      = 1'b0;
      climb_go   = 1'b0;
      climb_more = 1'b0;
      ram_req    = '0;

      if (accept) begin
         byte_in = in_byte;
         last_in = in_last;
      end

      unique case (state_ff)
         S_EXEC: begin
            role_in = ROLE_KIND;
            rlvl_in = '0;
            leaf_in = 1'b0;
            done_in = 1'b0;
            unique case (phase_ff)
               PH_KIND: begin
                  rlvl_in = level_ff;
                  if (byte_ff != (is_leaf ? KIND_LEAF : KIND_BRANCH)) begin
                     err_in   = STAT_KIND;
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_HEADER;
                     hcnt_in  = 2'd0;
                     hval_in  = '0;
                  end
               end
               PH_HEADER: begin
                  role_in = ROLE_LEN;
                  rlvl_in = level_ff;
                  hval_in = hval_shift;
                  if (hcnt_ff != 2'd3) begin
                     hcnt_in = hcnt_ff + 2'd1;
                  end else begin
                     hcnt_in = 2'd0;
                     if (is_leaf) begin
                        if (hval_shift != '0) begin
                           pleft_in = hval_shift;
                           phase_in = PH_PAYLOAD;
                        end else begin
                           leaf_in = 1'b1;
                           climb   = 1'b1;
                        end
                     end else if (hval_shift != '0) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = level_ff[PTR_W-1:0];
                        ram_req.wr_data = hval_shift;
                        level_in        = level_ff + LVL_ONE;
                        phase_in        = PH_KIND;
                     end else begin
                        climb = 1'b1;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  role_in  = ROLE_PAY;
                  rlvl_in  = level_ff;
                  pleft_in = pleft_ff - STK_ONE;
                  if (pleft_ff == STK_ONE) begin
                     leaf_in = 1'b1;
                     climb   = 1'b1;
                  end
               end
               PH_DONE: begin
                  err_in   = STAT_AFTER;
                  phase_in = PH_ERROR;
               end
               PH_ERROR: begin
               end
               default: begin
               end
            endcase
            if (climb) begin
               if (level_ff == '0) begin
                  phase_in = PH_DONE;
                  level_in = '0;
                  done_in  = 1'b1;
               end else begin
                  climb_go        = 1'b1;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = lvl_dec[PTR_W-1:0];
                  clv_in          = level_ff;
               end
            end
         end
         S_CLIMB: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = parent[PTR_W-1:0];
            ram_req.wr_data = cnt_dec;
            if (cnt_dec != '0) begin
               level_in = clv_ff;
               phase_in = PH_KIND;
            end else if (parent == '0) begin
               phase_in = PH_DONE;
               level_in = '0;
               done_in  = 1'b1;
            end else begin
               climb_more      = 1'b1;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = parent_dec[PTR_W-1:0];
               clv_in          = parent;
            end
         end
         S_EMIT: begin
            if (res_ready && last_ff) begin
               phase_in = PH_KIND;
               hcnt_in  = 2'd0;
               hval_in  = '0;
               pleft_in = '0;
               level_in = '0;
               err_in   = STAT_OK;
            end
         end
         S_IDLE: begin
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = climb_go ? S_CLIMB : S_EMIT;
         end
         S_CLIMB: begin
            state_in = climb_more ? S_CLIMB : S_EMIT;
         end
         S_EMIT: begin
            if (res_ready) begin
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      in_ready          = (state_ff == S_IDLE) || ((state_ff == S_EMIT) && res_ready);
      res_valid         = state_ff == S_EMIT;
      res_word.value    = byte_ff;
      res_word.role     = role_ff;
      res_word.level    = rlvl_ff;
      res_word.leaf_end = leaf_ff;
      res_word.done     = done_ff;
      if ((err_ff == STAT_OK) && last_ff && (phase_ff != PH_DONE)) begin
         res_word.status = STAT_CUT;
      end else begin
         res_word.status = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_KIND;
         hcnt_ff  <= 2'd0;
         hval_ff  <= '0;
         pleft_ff <= '0;
         level_ff <= '0;
         err_ff   <= STAT_OK;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         hval_ff  <= hval_in;
         pleft_ff <= pleft_in;
         level_ff <= level_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      clv_ff  <= clv_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      role_ff <= role_in;
      rlvl_ff <= rlvl_in;
      leaf_ff <= leaf_in;
      done_ff <= done_in;
   end

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
      else $error("stack read and write hit the same entry");

   a_climb_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLIMB) |-> (clv_ff != '0))
      else $error("unwind running at root level");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= MAX_LVL)
      else $error("nesting level beyond stack depth");

   a_err_holds: assert property (@(posedge clock) disable iff (reset)
      (err_ff != STAT_OK) |-> (phase_ff == PH_ERROR))
      else $error("error code set outside error phase");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && res_ready && last_ff)
         |=> ((phase_ff == PH_KIND) && (level_ff == '0) && (err_ff == STAT_OK)))
      else $error("message state not cleared after last word");

endmodule
`default_nettype wire

/* hw/rtl/nested_list_bytes_deframer.sv */
`default_nettype none
// ============================================================================
// nested_list_bytes_deframer
// Checks and splits a serialized tree of byte strings, one word at a time.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    data_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready    value, role, level, leaf end,
//                                              done, status
//   csr      in         csr_wr_en              list_depth (4 bits)
//
// a word passes through the exec and emit states, plus a climb step per stack
// level unwound when a node completes; the unwind reads and rewrites one child
// count per cycle in the stack RAM. a finished result sits in the output register
// while the next word is taken. synchronous reset clears control state and
// list_depth; no clearing pass is needed for the stack.
// ============================================================================
module nested_list_bytes_deframer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_last_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_byte_value,
   output logic [1:0]                     rsp_byte_role,
   output logic [nld_pkg::LVL_W-1:0]      rsp_node_level,
   output logic                           rsp_leaf_end,
   output logic                           rsp_message_done,
   output logic [1:0]                     rsp_status,
   input  wire logic                      csr_wr_en,
   input  wire logic [nld_pkg::LVL_W-1:0] csr_wr_data
);
   import nld_pkg::*;

   logic [LVL_W-1:0] list_depth_ff;
   ram_req_type      ram_req;
   logic [STK_W-1:0] ram_rd_data;
   logic             res_valid;
   logic             res_ready;
   rsp_type          res_word;
   rsp_type          out_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_depth_ff <= '0;
      end else if (csr_wr_en) begin
         list_depth_ff <= csr_wr_data;
      end
   end

   nld_ram #(
      .WIDTH (STK_W),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   nld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_byte     (req_data_byte),
      .in_last     (req_last_byte),
      .list_depth  (list_depth_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_word    (res_word),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   nld_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_word   (res_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_byte_value   = out_word.value;
   assign rsp_byte_role    = out_word.role;
   assign rsp_node_level   = out_word.level;
   assign rsp_leaf_end     = out_word.leaf_end;
   assign rsp_message_done = out_word.done;
   assign rsp_status       = out_word.status;

endmodule
`default_nettype wire

/* test/tb_nested_list_bytes_deframer.sv */
// ============================================================================
// tb_nested_list_bytes_deframer
// Byte-level check of the nested list deframer. A queue of words (well-formed
// trees at each depth, plus corrupted, cut-short, overrun and noise frames)
// feeds a valid/ready driver. A local predictor tracks the child-count stack
// and error state, and a monitor compares every result word field by field.
// Depth changes once mid-list, then between phases under several send/receive idle mixes.
// ============================================================================
module tb_nested_list_bytes_deframer;
   import nld_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int WORD_GOAL   = 1750;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_byte_value;
   logic [1:0]           rsp_byte_role;
   logic [LVL_W-1:0]     rsp_node_level;
   logic                 rsp_leaf_end;
   logic                 rsp_message_done;
   logic [1:0]           rsp_status;
   logic                 csr_wr_en = 1'b0;
   logic [LVL_W-1:0]     csr_wr_data = '0;

   // predictor state
   logic [LVL_W-1:0]     depth_reg = '0;
   phase_type            pr_phase = PH_KIND;
   logic [1:0]           hdr_cnt = '0;
   logic [31:0]          hdr_val = '0;
   logic [31:0]          pay_left = '0;
   int unsigned          cur_lvl = 0;
   logic [31:0]          kids_left [MAX_DEPTH];
   logic [1:0]           err_code = STAT_OK;

   stream_word_type      byte_stream_q[$];
   rsp_type              deframed_q[$];
   logic [7:0]           msg_q[$];
   int unsigned          kind_idx[$];
   stream_word_type      nxt_word;
   rsp_type              exp_rsp;

   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int unsigned          node_budget;
   int                   mismatches = 0;
   int                   word_total = 0;
   int                   msg_total = 0;
   int                   depth_writes = 0;
   int                   leaf_ends = 0;
   int                   msg_dones = 0;
   int                   status_seen [4] = '{0, 0, 0, 0};
   int                   cycles = 0;

   nested_list_bytes_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_role    (rsp_byte_role),
      .rsp_node_level   (rsp_node_level),
      .rsp_leaf_end     (rsp_leaf_end),
      .rsp_message_done (rsp_message_done),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void clear_message();
      pr_phase = PH_KIND;
      hdr_cnt  = '0;
      hdr_val  = '0;
      pay_left = '0;
      cur_lvl  = 0;
      err_code = STAT_OK;
      foreach (kids_left[i]) kids_left[i] = '0;
   endfunction

   // a node at level lvl has closed; pop counts until one still has children
   function automatic logic unwind_stack(input int unsigned lvl);
      int unsigned parent;
      int          guard;
      for (guard = 0; guard <= MAX_DEPTH; guard++) begin
         if (lvl == 0) begin
            pr_phase = PH_DONE;
            cur_lvl  = 0;
            return 1'b1;
         end
         parent = lvl - 1;
         if (parent >= MAX_DEPTH) begin
            pr_phase = PH_ERROR;
            err_code = STAT_KIND;
            return 1'b0;
         end
         kids_left[parent] = kids_left[parent] - 32'd1;
         if (kids_left[parent] != 0) begin
            cur_lvl  = lvl;
            pr_phase = PH_KIND;
            return 1'b0;
         end
         lvl = parent;
      end
      pr_phase = PH_DONE;
      cur_lvl  = 0;
      return 1'b1;
   endfunction

   function automatic rsp_type deframe_byte(input logic [7:0] b, input logic last);
      rsp_type     r;
      int unsigned lvl;
      int unsigned eff;
      logic        at_leaf;
      r        = '0;
      r.value  = b;
      lvl      = cur_lvl;
      eff      = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
      at_leaf  = (lvl >= eff);
      case (pr_phase)
         PH_KIND: begin
            r.role  = ROLE_KIND;
            r.level = LVL_W'(lvl);
            if (b != (at_leaf ? KIND_LEAF : KIND_BRANCH)) begin
               err_code = STAT_KIND;
               pr_phase = PH_ERROR;
            end else begin
               pr_phase = PH_HEADER;
               hdr_cnt  = '0;
               hdr_val  = '0;
            end
         end
         PH_HEADER: begin
            r.role  = ROLE_LEN;
            r.level = LVL_W'(lvl);
            hdr_val = {hdr_val[23:0], b};
            if (hdr_cnt < 2'd3) begin
               hdr_cnt = hdr_cnt + 2'd1;
            end else begin
               hdr_cnt = '0;
               if (at_leaf) begin
                  if (hdr_val != 0) begin
                     pay_left = hdr_val;
                     pr_phase = PH_PAYLOAD;
                  end else begin
                     r.leaf_end = 1'b1;
                     r.done     = unwind_stack(lvl);
                  end
               end else if (hdr_val != 0 && lvl < MAX_DEPTH) begin
                  kids_left[lvl] = hdr_val;
                  cur_lvl        = lvl + 1;
                  pr_phase       = PH_KIND;
               end else begin
                  r.done = unwind_stack(lvl);
               end
            end
         end
         PH_PAYLOAD: begin
            r.role   = ROLE_PAY;
            r.level  = LVL_W'(lvl);
            pay_left = pay_left - 32'd1;
            if (pay_left == 0) begin
               r.leaf_end = 1'b1;
               r.done     = unwind_stack(lvl);
            end
         end
         PH_DONE: begin
            err_code = STAT_AFTER;
            pr_phase = PH_ERROR;
         end
         default: begin
         end
      endcase
      if (last && err_code == STAT_OK && pr_phase != PH_DONE) err_code = STAT_CUT;
      r.status = err_code;
      if (last) clear_message();
      return r;
   endfunction

   function automatic void add_word(input logic [7:0] d, input logic last);
      stream_word_type w;
      w.data = d;
      w.last = last;
      byte_stream_q.push_back(w);
      word_total++;
   endfunction

   function automatic void put_be32(input logic [31:0] v);
      msg_q.push_back(v[31:24]);
      msg_q.push_back(v[23:16]);
      msg_q.push_back(v[15:8]);
      msg_q.push_back(v[7:0]);
   endfunction

   function automatic void gen_node(input int unsigned lvl, input int unsigned eff);
      int unsigned n;
      int unsigned i;
      logic [31:0] len;
      kind_idx.push_back(msg_q.size());
      if (lvl >= eff) begin
         msg_q.push_back(KIND_LEAF);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
         put_be32(len);
         repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         msg_q.push_back(KIND_BRANCH);
         if (node_budget > 0) begin
            n = $urandom_range(0, 3);
            node_budget = (n > node_budget) ? 0 : node_budget - n;
         end else begin
            n = $urandom_range(0, 1);
         end
         put_be32(n);
         for (i = 0; i < n; i++) gen_node(lvl + 1, eff);
      end
   endfunction

   // one message: mostly clean trees, the rest broken or noise
   function automatic void queue_message(input int unsigned eff);
      int unsigned pick;
      int unsigned stop;
      int unsigned i;
      msg_q.delete();
      kind_idx.delete();
      node_budget = (eff >= 5) ? $urandom_range(0, 3) : $urandom_range(1, 6);
      pick = $urandom_range(0, 99);
      gen_node(0, eff);
      stop = msg_q.size() - 1;
      if (pick < 70) begin
      end else if (pick < 78) begin
         i = kind_idx[$urandom_range(0, kind_idx.size() - 1)];
         msg_q[i] = msg_q[i] ^ 8'($urandom_range(1, 255));
      end else if (pick < 86) begin
         stop = $urandom_range(0, msg_q.size() - 2);
      end else if (pick < 93) begin
         repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
         stop = msg_q.size() - 1;
      end else if (pick < 97) begin
         msg_q.delete();
         msg_q.push_back((eff == 0) ? KIND_LEAF : KIND_BRANCH);
         put_be32($urandom());
         repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
         stop = msg_q.size() - 1;
      end else begin
         msg_q.delete();
         repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
         stop = msg_q.size() - 1;
      end
      for (i = 0; i <= stop; i++) add_word(msg_q[i], i == stop);
      msg_total++;
   endfunction

   task automatic wait_drained();
      while (byte_stream_q.size() != 0 || req_valid || deframed_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_depth(input logic [LVL_W-1:0] v);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      depth_reg = v;
      depth_writes++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframed_q.push_back(deframe_byte(req_data_byte, req_last_byte));
         end
         if (!req_valid || req_ready) begin
            if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt_word = byte_stream_q.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= nxt_word.data;
               req_last_byte <= nxt_word.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               exp_rsp = deframed_q.pop_front();
               check_field("byte_value", exp_rsp.value, rsp_byte_value);
               check_field("byte_role", 8'(exp_rsp.role), 8'(rsp_byte_role));
               check_field("node_level", 8'(exp_rsp.level), 8'(rsp_node_level));
               check_field("leaf_end", 8'(exp_rsp.leaf_end), 8'(rsp_leaf_end));
               check_field("message_done", 8'(exp_rsp.done), 8'(rsp_message_done));
               check_field("status", 8'(exp_rsp.status), 8'(rsp_status));
               leaf_ends += exp_rsp.leaf_end;
               msg_dones += exp_rsp.done;
               status_seen[exp_rsp.status]++;
            end
         end
      end
   end

   initial begin
      int          depth_plan [8];
      int          p;
      int          goal;
      int unsigned eff;
      depth_plan = '{0, 8, 3, 1, 15, 5, 2, 9};
      clear_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // depth 0: empty leaf then an overrun byte
      add_word(KIND_LEAF, 1'b0);
      repeat (4) add_word(8'h00, 1'b0);
      add_word(8'hFF, 1'b1);
      // wrong kind on a one-word message
      add_word(KIND_BRANCH, 1'b1);
      // cut short inside the header
      add_word(KIND_LEAF, 1'b0);
      add_word(8'h00, 1'b1);
      // one payload word
      add_word(KIND_LEAF, 1'b0);
      repeat (3) add_word(8'h00, 1'b0);
      add_word(8'h01, 1'b0);
      add_word(8'h00, 1'b1);
      // depth change between children of an open list
      write_depth(4'd1);
      add_word(KIND_BRANCH, 1'b0);
      repeat (3) add_word(8'h00, 1'b0);
      add_word(8'h02, 1'b0);
      add_word(KIND_LEAF, 1'b0);
      repeat (4) add_word(8'h00, 1'b0);
      write_depth(4'd15);
      add_word(KIND_BRANCH, 1'b0);
      repeat (3) add_word(8'h00, 1'b0);
      add_word(8'h00, 1'b1);

      for (p = 0; p < 8; p++) begin
         write_depth(LVL_W'(depth_plan[p]));
         send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 73 : 35) : 0;
         recv_stall_pct = (p % 4 == 2) ? 73 : ((p % 4 == 3) ? 35 : 0);
         eff  = (depth_plan[p] > MAX_DEPTH) ? MAX_DEPTH : depth_plan[p];
         goal = word_total + WORD_GOAL / 8;
         while (word_total < goal) queue_message(eff);
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d words in %0d messages over %0d depth writes", word_total,
               msg_total, depth_writes);
      $display("leaf ends %0d, message ends %0d, ok/kind/after/cut %0d/%0d/%0d/%0d",
               leaf_ends, msg_dones, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (mismatches == 0 && deframed_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/nld_pkg.sv
hw/rtl/nld_ram.sv
hw/rtl/nld_rsp_reg.sv
hw/rtl/nld_core.sv
hw/rtl/nested_list_bytes_deframer.sv
test/tb_nested_list_bytes_deframer.sv
